>>> sv/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PVS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define PVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> sv/pvs_pkg.sv
// Package: constants, types and saturation helper for the polynomial evaluator
`timescale 1ns / 1ps

package pvs_pkg;

	localparam int MAX_DEGREE = 6;
	localparam int NCOEF      = 7;
	localparam int DEG_W      = 3;
	localparam int Q_W        = 32;
	localparam int IDX_W      = 3;

	// register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_DEGREE = 3'd0;
	localparam logic [IDX_W-1:0] REG_COEF0  = 3'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VMUL,
		ST_VADD,
		ST_SINIT,
		ST_SMUL,
		ST_SADD,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL,
		OP_ADD,
		OP_SINIT
	} op_t;

	// control word from the sequencer to the shared multiply-add unit
	typedef struct packed {
		op_t              op;
		logic             use_slope;
		logic [DEG_W-1:0] coef_idx;
		logic [DEG_W-1:0] scale;
	} ctrl_t;

	typedef struct packed {
		logic signed [Q_W-1:0] q;
		logic                  hit;
	} sat_t;

	// clamp a wide signed value to the Q16.16 range
	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		if (v > 64'sd2147483647) begin
			r.q   = 32'sh7FFF_FFFF;
			r.hit = 1'b1;
		end else if (v < -64'sd2147483648) begin
			r.q   = 32'sh8000_0000;
			r.hit = 1'b1;
		end else begin
			r.q   = v[Q_W-1:0];
			r.hit = 1'b0;
		end
		return r;
	endfunction

endpackage

>>> sv/pvs_mac.sv
// Shared multiply, round, add and saturate unit with value and slope accumulators
`timescale 1ns / 1ps

module pvs_mac import pvs_pkg::*; (
	input  logic                  clk,
	input  ctrl_t                 ctrl,
	input  logic signed [Q_W-1:0] coef_sel,
	input  logic signed [Q_W-1:0] point,
	output logic signed [Q_W-1:0] val,
	output logic signed [Q_W-1:0] slp,
	output logic                  ovf
);

	logic signed [Q_W-1:0] val_q, slp_q, x_q, addend_q;
	logic signed [63:0]    prod_s1;
	logic                  ovf_q;

	logic signed [Q_W-1:0] mul_a;
	logic signed [63:0]    prod_d;
	logic signed [35:0]    coef_w, scale_w, scaled;
	logic signed [63:0]    prod_rnd;
	logic signed [47:0]    rnd;
	logic signed [48:0]    sum;
	sat_t                  scaled_sat, sum_sat;

	// full product of the running value or slope and x
	assign mul_a  = ctrl.use_slope ? slp_q : val_q;
	assign prod_d = mul_a * x_q;

	// coefficient scaled by its exponent, at most 6
	assign coef_w     = {{4{coef_sel[Q_W-1]}}, coef_sel};
	assign scale_w    = {33'b0, ctrl.scale};
	assign scaled     = coef_w * scale_w;
	assign scaled_sat = sat32({{28{scaled[35]}}, scaled});

	// round half up back to Q16.16, add the next (scaled) coefficient
	assign prod_rnd = prod_s1 + 64'sd32768;
	assign rnd      = prod_rnd[63:16];
	assign sum      = {rnd[47], rnd} + {{17{addend_q[Q_W-1]}}, addend_q};
	assign sum_sat  = sat32({{15{sum[48]}}, sum});

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				val_q <= coef_sel;
				slp_q <= '0;
				x_q   <= point;
				ovf_q <= 1'b0;
			end
			OP_MUL: begin
				prod_s1  <= prod_d;
				addend_q <= scaled_sat.q;
				ovf_q    <= ovf_q | scaled_sat.hit;
			end
			OP_ADD: begin
				if (ctrl.use_slope) begin
					slp_q <= sum_sat.q;
				end else begin
					val_q <= sum_sat.q;
				end
				ovf_q <= ovf_q | sum_sat.hit;
			end
			OP_SINIT: begin
				slp_q <= scaled_sat.q;
				ovf_q <= ovf_q | scaled_sat.hit;
			end
			default: begin
			end
		endcase
	end

	assign val = val_q;
	assign slp = slp_q;
	assign ovf = ovf_q;

endmodule

>>> sv/pvs_seq.sv
// Sequencer stepping the shared unit through the value and slope passes
`timescale 1ns / 1ps

module pvs_seq import pvs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [DEG_W-1:0] n_d,
	input  logic             out_free,
	output logic             in_ready,
	output logic             out_load,
	output ctrl_t            ctrl
);

	state_t           state_q, state_d;
	logic [DEG_W-1:0] n_q, i_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = (n_d == '0) ? ST_FIN : ST_VMUL;
			ST_VMUL:  state_d = ST_VADD;
			ST_VADD:  state_d = (i_q == n_q) ? ST_SINIT : ST_VMUL;
			ST_SINIT: state_d = (n_q == DEG_W'(1)) ? ST_FIN : ST_SMUL;
			ST_SMUL:  state_d = ST_SADD;
			ST_SADD:  state_d = (i_q == n_q - DEG_W'(1)) ? ST_FIN : ST_SMUL;
			ST_FIN:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready       = 1'b0;
		out_load       = 1'b0;
		ctrl.op        = OP_NONE;
		ctrl.use_slope = 1'b0;
		ctrl.coef_idx  = '0;
		ctrl.scale     = DEG_W'(1);
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) ctrl.op = OP_LOAD;
			end
			ST_VMUL: begin
				ctrl.op       = OP_MUL;
				ctrl.coef_idx = i_q;
			end
			ST_VADD: ctrl.op = OP_ADD;
			ST_SINIT: begin
				ctrl.op    = OP_SINIT;
				ctrl.scale = n_q;
			end
			ST_SMUL: begin
				ctrl.op        = OP_MUL;
				ctrl.use_slope = 1'b1;
				ctrl.coef_idx  = i_q;
				ctrl.scale     = n_q - i_q;
			end
			ST_SADD: begin
				ctrl.op        = OP_ADD;
				ctrl.use_slope = 1'b1;
			end
			ST_FIN:  out_load = out_free;
			default: begin
			end
		endcase
	end

	// state, degree in use and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			i_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_valid) begin
				n_q <= n_d;
				i_q <= DEG_W'(1);
			end else if (state_q == ST_VADD) begin
				i_q <= (i_q == n_q) ? DEG_W'(1) : i_q + DEG_W'(1);
			end else if (state_q == ST_SADD) begin
				i_q <= i_q + DEG_W'(1);
			end
		end
	end

endmodule

>>> sv/polynomial_value_and_slope.sv
// A request runs a value pass, then a slope pass, on the single shared multiply-add
// unit, with a multiply and an add state per Horner step; degree 0 skips both passes.
// The next request is taken only once the result has gone to the output register.
// A finished result waits in the output register while the next request is taken.
// Reset (arst_n, asynchronous, active low) clears degree, coefficients and control.
`timescale 1ns / 1ps

module polynomial_value_and_slope import pvs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [IDX_W-1:0]      cfg_index,
	input  logic [Q_W-1:0]        cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [Q_W-1:0] point,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [Q_W-1:0] value,
	output logic signed [Q_W-1:0] slope,
	output logic                  overflow
);

	logic [DEG_W-1:0]      degree_q;
	logic signed [Q_W-1:0] coef_q [NCOEF];
	logic [DEG_W-1:0]      n_d;
	logic                  out_free, out_load;
	ctrl_t                 ctrl;
	logic signed [Q_W-1:0] mac_val, mac_slp;
	logic                  mac_ovf;
	logic signed [Q_W-1:0] value_q, slope_q;
	logic                  overflow_q, out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
			for (int k = 0; k < NCOEF; k++) coef_q[k] <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_DEGREE) begin
				degree_q <= cfg_data[DEG_W-1:0];
			end else begin
				coef_q[cfg_index - REG_COEF0] <= cfg_data;
			end
		end
	end

	// degree in use, capped
	assign n_d = (degree_q > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree_q;

	assign out_free = !out_valid_q || out_ready;

	pvs_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.n_d      (n_d),
		.out_free (out_free),
		.in_ready (in_ready),
		.out_load (out_load),
		.ctrl     (ctrl)
	);

	pvs_mac u_mac (
		.clk      (clk),
		.ctrl     (ctrl),
		.coef_sel (coef_q[ctrl.coef_idx]),
		.point    (point),
		.val      (mac_val),
		.slp      (mac_slp),
		.ovf      (mac_ovf)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value_q    <= mac_val;
			slope_q    <= mac_slp;
			overflow_q <= mac_ovf;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign slope     = slope_q;
	assign overflow  = overflow_q;

endmodule

>>> sv/pvs_checker.sv
// Port-level checker for the polynomial evaluator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pvs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] value,
	input logic [31:0] slope,
	input logic        overflow
);

	// no second request while one is being worked on
	`PVS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// a result only appears once the work on a request is finished
	`PVS_ASSERT_IMPL(a_result_after_work, clk, arst_n, $rose(out_valid), !$past(in_ready))

	// a result never appears straight after its request is accepted
	`PVS_ASSERT_NEXT(a_no_instant_result, clk, arst_n, in_valid && in_ready, !$rose(out_valid))

	// a waiting result holds
	`PVS_ASSERT_NEXT(a_result_holds, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(value) && $stable(slope) && $stable(overflow))

endmodule

bind polynomial_value_and_slope pvs_checker u_pvs_checker (.*);
